>>> sv/rk4do_pkg.sv
// ----------------------------------------------------------------------------
// rk4do_pkg
// Shared types, codes and the microcode program of the RK4 oscillator block.
// ----------------------------------------------------------------------------
package rk4do_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_STEP_SIZE  = 3'd0;
    localparam logic [2:0] CFG_START_X    = 3'd1;
    localparam logic [2:0] CFG_START_Y    = 3'd2;
    localparam logic [2:0] CFG_START_DY   = 3'd3;
    localparam logic [2:0] CFG_STEP_COUNT = 3'd4;

    // register reset values
    localparam logic [24:0] RST_STEP_SIZE  = 25'd167772;
    localparam logic [31:0] RST_START_X    = 32'd0;
    localparam logic [31:0] RST_START_Y    = 32'd0;
    localparam logic [31:0] RST_START_DY   = 32'd33554432;
    localparam logic [15:0] RST_STEP_COUNT = 16'd100;

    // divide by six, one quotient bit per cycle
    localparam logic [3:0] DIV_BY   = 4'd6;
    localparam logic [2:0] DIV_HALF = 3'd3;

    // program layout
    localparam int unsigned PC_W = 5;
    localparam logic [PC_W-1:0] LOOP_PC  = 5'd2;
    localparam logic [PC_W-1:0] FINAL_PC = 5'd20;
    localparam logic [PC_W-1:0] LAST_PC  = 5'd26;

    localparam logic [1:0] FIRST_STAGE = 2'd0;
    localparam logic [1:0] H_STAGE     = 2'd2;
    localparam logic [1:0] LAST_STAGE  = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_NEG,
        OP_MUL,
        OP_DIV,
        OP_BRL,
        OP_JMP
    } op_t;

    typedef enum logic [3:0] {
        R_ZERO,
        R_Y,
        R_DY,
        R_X,
        R_TA,
        R_TB,
        R_T1,
        R_T2,
        R_KA,
        R_KB,
        R_SA,
        R_SB,
        R_H,
        R_HS
    } reg_sel_t;

    // za: operand a reads zero in the first stage
    // zb: operand b reads zero outside the two middle stages
    typedef struct packed {
        op_t      op;
        reg_sel_t dst;
        reg_sel_t src_a;
        reg_sel_t src_b;
        logic     za;
        logic     zb;
    } uinstr_t;

    typedef struct packed {
        logic load;
        logic run;
    } core_cmd_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_WAIT
    } core_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_CALC,
        TS_HOLD
    } top_state_t;

    function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
        uinstr_t u;
        case (pc)
            // stage inputs for the first stage
            5'd0:  u = '{OP_ADD, R_TA, R_Y,    R_ZERO, 1'b0, 1'b0};
            5'd1:  u = '{OP_ADD, R_TB, R_DY,   R_ZERO, 1'b0, 1'b0};
            // slopes: ka = tb, kb = -2*tb - 5*ta
            5'd2:  u = '{OP_ADD, R_KA, R_TB,   R_ZERO, 1'b0, 1'b0};
            5'd3:  u = '{OP_ADD, R_T1, R_TA,   R_TA,   1'b0, 1'b0};
            5'd4:  u = '{OP_ADD, R_T1, R_T1,   R_T1,   1'b0, 1'b0};
            5'd5:  u = '{OP_ADD, R_T1, R_T1,   R_TA,   1'b0, 1'b0};
            5'd6:  u = '{OP_ADD, R_T2, R_TB,   R_TB,   1'b0, 1'b0};
            5'd7:  u = '{OP_NEG, R_T2, R_T2,   R_ZERO, 1'b0, 1'b0};
            5'd8:  u = '{OP_NEG, R_T1, R_T1,   R_ZERO, 1'b0, 1'b0};
            5'd9:  u = '{OP_ADD, R_KB, R_T2,   R_T1,   1'b0, 1'b0};
            // weighted sums, weights 1 2 2 1
            5'd10: u = '{OP_ADD, R_T1, R_KA,   R_KA,   1'b0, 1'b1};
            5'd11: u = '{OP_ADD, R_SA, R_SA,   R_T1,   1'b1, 1'b0};
            5'd12: u = '{OP_ADD, R_T1, R_KB,   R_KB,   1'b0, 1'b1};
            5'd13: u = '{OP_ADD, R_SB, R_SB,   R_T1,   1'b1, 1'b0};
            5'd14: u = '{OP_BRL, R_ZERO, R_ZERO, R_ZERO, 1'b0, 1'b0};
            // inputs of the next stage
            5'd15: u = '{OP_MUL, R_T1, R_HS,   R_KA,   1'b0, 1'b0};
            5'd16: u = '{OP_ADD, R_TA, R_Y,    R_T1,   1'b0, 1'b0};
            5'd17: u = '{OP_MUL, R_T1, R_HS,   R_KB,   1'b0, 1'b0};
            5'd18: u = '{OP_ADD, R_TB, R_DY,   R_T1,   1'b0, 1'b0};
            5'd19: u = '{OP_JMP, R_ZERO, R_ZERO, R_ZERO, 1'b0, 1'b0};
            // state update
            5'd20: u = '{OP_MUL, R_T1, R_H,    R_SA,   1'b0, 1'b0};
            5'd21: u = '{OP_DIV, R_T1, R_T1,   R_ZERO, 1'b0, 1'b0};
            5'd22: u = '{OP_ADD, R_Y,  R_Y,    R_T1,   1'b0, 1'b0};
            5'd23: u = '{OP_MUL, R_T1, R_H,    R_SB,   1'b0, 1'b0};
            5'd24: u = '{OP_DIV, R_T1, R_T1,   R_ZERO, 1'b0, 1'b0};
            5'd25: u = '{OP_ADD, R_DY, R_DY,   R_T1,   1'b0, 1'b0};
            5'd26: u = '{OP_ADD, R_X,  R_X,    R_H,    1'b0, 1'b0};
            default: u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO, 1'b0, 1'b0};
        endcase
        return u;
    endfunction

endpackage

>>> sv/rk4do_mul.sv
// ----------------------------------------------------------------------------
// rk4do_mul
// Shift-add fixed-point multiplier, one multiplier bit per cycle, with
// round-half-away rounding and saturation.
// ----------------------------------------------------------------------------
module rk4do_mul #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] op_a,
    input  logic [VALUE_WIDTH-1:0] op_b,
    output logic [VALUE_WIDTH-1:0] product,
    output logic                   done
);

    localparam int VW    = VALUE_WIDTH;
    localparam int PW    = 2 * VW + 1;
    localparam int CNT_W = $clog2(VW + 1);
    localparam logic [PW-1:0] RND  = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] HALF = PW'(1) << (VW - 1);

    logic [VW-1:0]    ma_reg;
    logic [VW-1:0]    hi_reg;
    logic [VW-1:0]    lo_reg;
    logic [VW-1:0]    mag_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [VW-1:0] mag_a;
    logic [VW-1:0] mag_b;
    logic [VW:0]   psum;
    logic [PW-1:0] rounded;
    logic [PW-1:0] lim;
    logic [VW-1:0] mag_next;

    assign mag_a = op_a[VW-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[VW-1] ? (~op_b + 1'b1) : op_b;
    assign psum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, ma_reg} : '0);

    always_comb begin
        rounded  = ({1'b0, hi_reg, lo_reg} + RND) >> FRAC_BITS;
        lim      = neg_reg ? HALF : HALF - 1'b1;
        mag_next = (rounded > lim) ? lim[VW-1:0] : rounded[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VW);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg  <= mag_a;
            hi_reg  <= '0;
            lo_reg  <= mag_b;
            neg_reg <= op_a[VW-1] ^ op_b[VW-1];
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                hi_reg <= psum[VW:1];
                lo_reg <= {psum[0], lo_reg[VW-1:1]};
            end else begin
                mag_reg <= mag_next;
            end
        end
    end

    assign product = (neg_reg ? ~mag_reg : mag_reg) + VW'(neg_reg);
    assign done    = done_reg;

endmodule

>>> sv/rk4do_div6.sv
// ----------------------------------------------------------------------------
// rk4do_div6
// Bit-serial divide by six of a signed value, one quotient bit per cycle,
// rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module rk4do_div6 #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic                   done
);

    localparam int VW    = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VW + 1);

    logic [VW-1:0]    qm_reg;
    logic [2:0]       rem_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [VW-1:0] mag_in;
    logic [3:0]    trial;
    logic          ge;
    logic          rnd;

    assign mag_in = dividend[VW-1] ? (~dividend + 1'b1) : dividend;
    assign trial  = {rem_reg, qm_reg[VW-1]};
    assign ge     = trial >= rk4do_pkg::DIV_BY;
    assign rnd    = rem_reg >= rk4do_pkg::DIV_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VW);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qm_reg  <= mag_in;
            rem_reg <= '0;
            neg_reg <= dividend[VW-1];
        end else if (busy_reg && (cnt_reg != '0)) begin
            qm_reg  <= {qm_reg[VW-2:0], ge};
            rem_reg <= ge ? 3'(trial - rk4do_pkg::DIV_BY) : trial[2:0];
        end
    end

    // -(q + r) folded into one adder: ~q + !r
    assign quotient = (neg_reg ? ~qm_reg : qm_reg) + VW'(neg_reg ^ rnd);
    assign done     = done_reg;

endmodule

>>> sv/rk4do_core.sv
// ----------------------------------------------------------------------------
// rk4do_core
// Microcoded RK4 sequencer: holds the point and the stage values, runs one
// saturating add per cycle, stalling while serial units multiply or divide.
// ----------------------------------------------------------------------------
module rk4do_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rk4do_pkg::core_cmd_t   cmd,
    input  logic [VALUE_WIDTH-1:0] load_x,
    input  logic [VALUE_WIDTH-1:0] load_y,
    input  logic [VALUE_WIDTH-1:0] load_dy,
    input  logic [VALUE_WIDTH-1:0] step_h,
    output logic [VALUE_WIDTH-1:0] cur_x,
    output logic [VALUE_WIDTH-1:0] cur_y,
    output logic [VALUE_WIDTH-1:0] cur_dy,
    output logic                   done
);

    localparam int VW = VALUE_WIDTH;
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    rk4do_pkg::core_state_t state_reg, state_next;
    logic [rk4do_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [1:0] stage_reg, stage_next;
    logic done_reg, done_next;

    logic [VW-1:0] x_reg, y_reg, dy_reg;
    logic [VW-1:0] ta_reg, tb_reg, t1_reg, t2_reg;
    logic [VW-1:0] ka_reg, kb_reg, sa_reg, sb_reg;

    rk4do_pkg::uinstr_t uop;
    logic [VW-1:0] hs;
    logic [VW-1:0] opa, opb;
    logic [VW-1:0] wb_val;
    logic          wr_en;
    logic          mul_start, div_start;
    logic [VW-1:0] mul_product, div_quotient;
    logic          mul_done, div_done;
    logic          unit_done;
    logic          first_stage, mid_stage;

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) begin
            return a[VW-1] ? VMIN : VMAX;
        end
        return s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] sat_neg(input logic [VW-1:0] a);
        if (a == VMIN) begin
            return VMAX;
        end
        return ~a + 1'b1;
    endfunction

    assign uop         = rk4do_pkg::ucode(pc_reg);
    assign first_stage = stage_reg == rk4do_pkg::FIRST_STAGE;
    assign mid_stage   = (stage_reg != rk4do_pkg::FIRST_STAGE)
                      && (stage_reg != rk4do_pkg::LAST_STAGE);
    assign hs          = (stage_reg == rk4do_pkg::H_STAGE) ? step_h : {1'b0, step_h[VW-1:1]};

    always_comb begin
        case (uop.src_a)
            rk4do_pkg::R_Y:  opa = y_reg;
            rk4do_pkg::R_DY: opa = dy_reg;
            rk4do_pkg::R_X:  opa = x_reg;
            rk4do_pkg::R_TA: opa = ta_reg;
            rk4do_pkg::R_TB: opa = tb_reg;
            rk4do_pkg::R_T1: opa = t1_reg;
            rk4do_pkg::R_T2: opa = t2_reg;
            rk4do_pkg::R_KA: opa = ka_reg;
            rk4do_pkg::R_KB: opa = kb_reg;
            rk4do_pkg::R_SA: opa = sa_reg;
            rk4do_pkg::R_SB: opa = sb_reg;
            rk4do_pkg::R_H:  opa = step_h;
            rk4do_pkg::R_HS: opa = hs;
            default:         opa = '0;
        endcase
        if (uop.za && first_stage) begin
            opa = '0;
        end
    end

    always_comb begin
        case (uop.src_b)
            rk4do_pkg::R_Y:  opb = y_reg;
            rk4do_pkg::R_DY: opb = dy_reg;
            rk4do_pkg::R_X:  opb = x_reg;
            rk4do_pkg::R_TA: opb = ta_reg;
            rk4do_pkg::R_TB: opb = tb_reg;
            rk4do_pkg::R_T1: opb = t1_reg;
            rk4do_pkg::R_T2: opb = t2_reg;
            rk4do_pkg::R_KA: opb = ka_reg;
            rk4do_pkg::R_KB: opb = kb_reg;
            rk4do_pkg::R_SA: opb = sa_reg;
            rk4do_pkg::R_SB: opb = sb_reg;
            rk4do_pkg::R_H:  opb = step_h;
            rk4do_pkg::R_HS: opb = hs;
            default:         opb = '0;
        endcase
        if (uop.zb && !mid_stage) begin
            opb = '0;
        end
    end

    always_comb begin
        case (uop.op)
            rk4do_pkg::OP_ADD: wb_val = sat_add(opa, opb);
            rk4do_pkg::OP_NEG: wb_val = sat_neg(opa);
            rk4do_pkg::OP_MUL: wb_val = mul_product;
            rk4do_pkg::OP_DIV: wb_val = div_quotient;
            default:           wb_val = opa;
        endcase
    end

    assign unit_done = (uop.op == rk4do_pkg::OP_MUL) ? mul_done : div_done;

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        stage_next = stage_reg;
        done_next  = 1'b0;
        wr_en      = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            rk4do_pkg::CS_IDLE: begin
                if (cmd.run) begin
                    state_next = rk4do_pkg::CS_EXEC;
                    pc_next    = '0;
                    stage_next = rk4do_pkg::FIRST_STAGE;
                end
            end
            rk4do_pkg::CS_EXEC: begin
                case (uop.op)
                    rk4do_pkg::OP_ADD, rk4do_pkg::OP_NEG: begin
                        wr_en = 1'b1;
                        if (pc_reg == rk4do_pkg::LAST_PC) begin
                            state_next = rk4do_pkg::CS_IDLE;
                            done_next  = 1'b1;
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    rk4do_pkg::OP_MUL: begin
                        mul_start  = 1'b1;
                        state_next = rk4do_pkg::CS_WAIT;
                    end
                    rk4do_pkg::OP_DIV: begin
                        div_start  = 1'b1;
                        state_next = rk4do_pkg::CS_WAIT;
                    end
                    rk4do_pkg::OP_BRL: begin
                        pc_next = (stage_reg == rk4do_pkg::LAST_STAGE)
                                ? rk4do_pkg::FINAL_PC : pc_reg + 1'b1;
                    end
                    rk4do_pkg::OP_JMP: begin
                        stage_next = stage_reg + 1'b1;
                        pc_next    = rk4do_pkg::LOOP_PC;
                    end
                    default: begin
                        state_next = rk4do_pkg::CS_IDLE;
                    end
                endcase
            end
            rk4do_pkg::CS_WAIT: begin
                if (unit_done) begin
                    wr_en      = 1'b1;
                    pc_next    = pc_reg + 1'b1;
                    state_next = rk4do_pkg::CS_EXEC;
                end
            end
            default: begin
                state_next = rk4do_pkg::CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rk4do_pkg::CS_IDLE;
            pc_reg    <= '0;
            stage_reg <= rk4do_pkg::FIRST_STAGE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    // integration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg  <= '0;
            y_reg  <= '0;
            dy_reg <= '0;
        end else if (cmd.load) begin
            x_reg  <= load_x;
            y_reg  <= load_y;
            dy_reg <= load_dy;
        end else if (wr_en) begin
            case (uop.dst)
                rk4do_pkg::R_X:  x_reg  <= wb_val;
                rk4do_pkg::R_Y:  y_reg  <= wb_val;
                rk4do_pkg::R_DY: dy_reg <= wb_val;
                default: ;
            endcase
        end
    end

    // stage scratch values
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (uop.dst)
                rk4do_pkg::R_TA: ta_reg <= wb_val;
                rk4do_pkg::R_TB: tb_reg <= wb_val;
                rk4do_pkg::R_T1: t1_reg <= wb_val;
                rk4do_pkg::R_T2: t2_reg <= wb_val;
                rk4do_pkg::R_KA: ka_reg <= wb_val;
                rk4do_pkg::R_KB: kb_reg <= wb_val;
                rk4do_pkg::R_SA: sa_reg <= wb_val;
                rk4do_pkg::R_SB: sb_reg <= wb_val;
                default: ;
            endcase
        end
    end

    rk4do_mul #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (opa),
        .op_b    (opb),
        .product (mul_product),
        .done    (mul_done)
    );

    rk4do_div6 #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div6 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (opa),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign cur_x  = x_reg;
    assign cur_y  = y_reg;
    assign cur_dy = dy_reg;
    assign done   = done_reg;

endmodule

>>> sv/rk4_damped_oscillator_step_top.sv
// ----------------------------------------------------------------------------
// rk4_damped_oscillator_step_top
// RK4 step of y'' + 2y' + 5y = 0 in signed fixed point, one point per beat.
// A restart, or an advance past the last step, goes from the input beat
// through the hold state to the output registers; an integrating advance
// first runs the core, whose run time is set by the eight
// bit-serial products and two bit-serial divisions by six of one step.
// Throughput: one item at a time; the next beat is taken while a result waits.
// Reset clears the point, the step count and the handshakes and loads the
// register defaults.
// ----------------------------------------------------------------------------
module rk4_damped_oscillator_step_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 24,
    parameter int COUNT_WIDTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] restart
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // point_x, point_y, point_dy, step_number
    output logic         m_tlast
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int WW = (VW > 32) ? VW : 32;
    localparam int WH = (VW > 26) ? VW : 26;
    localparam int WC = (CW > 16) ? CW : 16;
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    logic [24:0] step_size_reg;
    logic [31:0] start_x_reg;
    logic [31:0] start_y_reg;
    logic [31:0] start_dy_reg;
    logic [15:0] step_count_reg;

    rk4do_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0] steps_done_reg, steps_done_next;
    logic          m_tvalid_reg;
    logic [31:0]   out_x_reg, out_y_reg, out_dy_reg;
    logic [15:0]   out_step_reg;
    logic          out_last_reg;

    rk4do_pkg::core_cmd_t core_cmd;
    logic          core_done;
    logic          out_load;
    logic [VW-1:0] core_x, core_y, core_dy;
    logic [VW-1:0] h_val;
    logic [WH-1:0] h_ext;
    logic [WC-1:0] count_ext;
    logic [WC-1:0] steps_ext;
    logic [CW-1:0] n_steps;
    logic [WW-1:0] x_ext, y_ext, dy_ext;

    function automatic logic [VW-1:0] load_sat(input logic [31:0] r);
        logic [WW-1:0]    e;
        logic [WW-VW:0]   hi;
        e  = WW'(signed'(r));
        hi = e[WW-1:VW-1];
        if ((&hi) || !(|hi)) begin
            return e[VW-1:0];
        end
        return r[31] ? VMIN : VMAX;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg  <= rk4do_pkg::RST_STEP_SIZE;
            start_x_reg    <= rk4do_pkg::RST_START_X;
            start_y_reg    <= rk4do_pkg::RST_START_Y;
            start_dy_reg   <= rk4do_pkg::RST_START_DY;
            step_count_reg <= rk4do_pkg::RST_STEP_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rk4do_pkg::CFG_STEP_SIZE:  step_size_reg  <= cfg_data[24:0];
                rk4do_pkg::CFG_START_X:    start_x_reg    <= cfg_data;
                rk4do_pkg::CFG_START_Y:    start_y_reg    <= cfg_data;
                rk4do_pkg::CFG_START_DY:   start_dy_reg   <= cfg_data;
                rk4do_pkg::CFG_STEP_COUNT: step_count_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign h_ext     = WH'(step_size_reg);
    assign h_val     = (|h_ext[WH-1:VW-1]) ? VMAX : h_ext[VW-1:0];
    assign count_ext = WC'(step_count_reg);
    assign n_steps   = count_ext[CW-1:0];

    always_comb begin
        state_next      = state_reg;
        steps_done_next = steps_done_reg;
        core_cmd        = '0;
        out_load        = 1'b0;
        s_tready        = 1'b0;
        case (state_reg)
            rk4do_pkg::TS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tdata[0]) begin
                        core_cmd.load   = 1'b1;
                        steps_done_next = '0;
                        state_next      = rk4do_pkg::TS_HOLD;
                    end else if (steps_done_reg < n_steps) begin
                        core_cmd.run = 1'b1;
                        state_next   = rk4do_pkg::TS_CALC;
                    end else begin
                        state_next = rk4do_pkg::TS_HOLD;
                    end
                end
            end
            rk4do_pkg::TS_CALC: begin
                if (core_done) begin
                    steps_done_next = steps_done_reg + 1'b1;
                    state_next      = rk4do_pkg::TS_HOLD;
                end
            end
            rk4do_pkg::TS_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = rk4do_pkg::TS_IDLE;
                end
            end
            default: begin
                state_next = rk4do_pkg::TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rk4do_pkg::TS_IDLE;
            steps_done_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            steps_done_reg <= steps_done_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign x_ext     = WW'(signed'(core_x));
    assign y_ext     = WW'(signed'(core_y));
    assign dy_ext    = WW'(signed'(core_dy));
    assign steps_ext = WC'(steps_done_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg    <= x_ext[31:0];
            out_y_reg    <= y_ext[31:0];
            out_dy_reg   <= dy_ext[31:0];
            out_step_reg <= steps_ext[15:0];
            out_last_reg <= steps_done_reg >= n_steps;
        end
    end

    rk4do_core #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (core_cmd),
        .load_x  (load_sat(start_x_reg)),
        .load_y  (load_sat(start_y_reg)),
        .load_dy (load_sat(start_dy_reg)),
        .step_h  (h_val),
        .cur_x   (core_x),
        .cur_y   (core_y),
        .cur_dy  (core_dy),
        .done    (core_done)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_step_reg, out_dy_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> test/rk4_damped_oscillator_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4_damped_oscillator_step_top_tb
// Self-checking bench for the RK4 damped oscillator step. A scoreboard class
// keeps its own fixed-point copy of the integrator and the register file. It
// predicts x, y, y', the step index and the last flag for every input beat
// and compares each result beat in order. The run goes through directed
// corner cases first: advance before restart, saturation, zero step, zero
// count, runs past the last step and register changes mid-run. Random
// phases with random register settings and restart/advance sequences follow,
// with stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module rk4_damped_oscillator_step_top_tb;

    localparam int     FRAC        = 24;
    localparam int     ITEMS       = 950;
    localparam int     CALM_TAIL   = 100;
    localparam int     LONG_HOLD   = 1500;
    localparam int     STALL_LIMIT = 6000;
    localparam int     END_WAIT    = 450;
    localparam longint VMAX        = 64'sd2147483647;
    localparam longint VMIN        = -64'sd2147483648;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] dy;
        logic [15:0] step;
        logic        last;
    } point_t;

    class oscillator_board;
        logic [24:0] h_reg;
        logic [31:0] x0_reg;
        logic [31:0] y0_reg;
        logic [31:0] dy0_reg;
        logic [15:0] n_reg;
        longint      px;
        longint      py;
        longint      pdy;
        int unsigned done_steps;
        point_t      pending_points[$];
        int unsigned mismatches;

        function new();
            h_reg      = rk4do_pkg::RST_STEP_SIZE;
            x0_reg     = rk4do_pkg::RST_START_X;
            y0_reg     = rk4do_pkg::RST_START_Y;
            dy0_reg    = rk4do_pkg::RST_START_DY;
            n_reg      = rk4do_pkg::RST_STEP_COUNT;
            px         = 0;
            py         = 0;
            pdy        = 0;
            done_steps = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                rk4do_pkg::CFG_STEP_SIZE:  h_reg   = data[24:0];
                rk4do_pkg::CFG_START_X:    x0_reg  = data;
                rk4do_pkg::CFG_START_Y:    y0_reg  = data;
                rk4do_pkg::CFG_START_DY:   dy0_reg = data;
                rk4do_pkg::CFG_STEP_COUNT: n_reg   = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > VMAX) return VMAX;
            if (v < VMIN) return VMIN;
            return v;
        endfunction

        function longint sadd(longint a, longint b);
            return clamp(a + b);
        endfunction

        function longint sneg(longint a);
            return clamp(-a);
        endfunction

        function longint from_mag(bit neg, longint unsigned m);
            longint unsigned lim;
            lim = neg ? 64'd2147483648 : 64'd2147483647;
            if (m > lim) m = lim;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // exact product, rounded half away from zero, saturated
        function longint fmul(longint a, longint b);
            bit              neg;
            longint unsigned m;
            neg = (a < 0) != (b < 0);
            m = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
            m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
            return from_mag(neg, m);
        endfunction

        function longint div6(longint a);
            longint unsigned m;
            longint unsigned q;
            m = (a < 0) ? longint'(-a) : longint'(a);
            q = m / 6 + (((m % 6) >= 3) ? 1 : 0);
            return from_mag(a < 0, q);
        endfunction

        // y'' = -2y' - 5y
        function longint accel(longint y, longint dy);
            longint y2;
            longint y5;
            y2 = sadd(y, y);
            y5 = sadd(sadd(y2, y2), y);
            return sadd(sneg(sadd(dy, dy)), sneg(y5));
        endfunction

        function longint weigh(longint k1, longint k2, longint k3, longint k4);
            longint s;
            s = sadd(k1, sadd(k2, k2));
            s = sadd(s, sadd(k3, k3));
            return sadd(s, k4);
        endfunction

        function void take_step();
            longint h, hh, ta, tb;
            longint k1a, k1b, k2a, k2b, k3a, k3b, k4a, k4b;
            h   = clamp(longint'(h_reg));
            hh  = h >>> 1;
            k1a = pdy;
            k1b = accel(py, pdy);
            ta  = sadd(py, fmul(hh, k1a));
            tb  = sadd(pdy, fmul(hh, k1b));
            k2a = tb;
            k2b = accel(ta, tb);
            ta  = sadd(py, fmul(hh, k2a));
            tb  = sadd(pdy, fmul(hh, k2b));
            k3a = tb;
            k3b = accel(ta, tb);
            ta  = sadd(py, fmul(h, k3a));
            tb  = sadd(pdy, fmul(h, k3b));
            k4a = tb;
            k4b = accel(ta, tb);
            py  = sadd(py, div6(fmul(h, weigh(k1a, k2a, k3a, k4a))));
            pdy = sadd(pdy, div6(fmul(h, weigh(k1b, k2b, k3b, k4b))));
            px  = sadd(px, h);
        endfunction

        function void note_input(bit restart);
            point_t p;
            if (restart) begin
                px         = clamp(longint'(signed'(x0_reg)));
                py         = clamp(longint'(signed'(y0_reg)));
                pdy        = clamp(longint'(signed'(dy0_reg)));
                done_steps = 0;
            end else if (done_steps < n_reg) begin
                take_step();
                done_steps++;
            end
            p.x    = px[31:0];
            p.y    = py[31:0];
            p.dy   = pdy[31:0];
            p.step = done_steps[15:0];
            p.last = (done_steps >= n_reg);
            pending_points.push_back(p);
        endfunction

        function void check_result(point_t got);
            point_t want;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: step %0d x %h y %h dy %h last %b",
                             got.step, got.x, got.y, got.dy, got.last);
                return;
            end
            want = pending_points.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.dy !== want.dy ||
                got.step !== want.step || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected x %h y %h dy %h step %0d last %b",
                             want.x, want.y, want.dy, want.step, want.last);
                    $display("          actual   x %h y %h dy %h step %0d last %b",
                             got.x, got.y, got.dy, got.step, got.last);
                end
            end
        endfunction

        function int pending();
            return pending_points.size();
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [31:0]   cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [7:0]    s_tdata;   // [0] restart
    logic          m_tvalid;
    logic          m_tready;
    logic [111:0]  m_tdata;   // point_x, point_y, point_dy, step_number
    logic          m_tlast;

    oscillator_board board = new();
    int  sent;
    bit  idle_on;
    bit  hold_request;

    rk4_damped_oscillator_step_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic write_regs(input logic [31:0] step_word, x_word, y_word, dy_word,
                              count_word);
        logic [31:0] words [5];
        words[rk4do_pkg::CFG_STEP_SIZE]  = step_word;
        words[rk4do_pkg::CFG_START_X]    = x_word;
        words[rk4do_pkg::CFG_START_Y]    = y_word;
        words[rk4do_pkg::CFG_START_DY]   = dy_word;
        words[rk4do_pkg::CFG_STEP_COUNT] = count_word;
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= words[i];
            do @(posedge aclk); while (!cfg_ready);
            board.set_reg(3'(i), words[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input bit restart);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        board.note_input(restart);
        sent++;
    endtask

    task automatic send_run(input bit first_restart, input int advances);
        send_item(first_restart);
        repeat (advances) send_item(1'b0);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_start();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
        endcase
    endfunction

    // result side: check every beat, stall in bursts or one long hold-off
    initial begin
        int     stall_left;
        point_t got;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.x    = m_tdata[31:0];
                got.y    = m_tdata[63:32];
                got.dy   = m_tdata[95:64];
                got.step = m_tdata[111:96];
                got.last = m_tlast;
                board.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("rk4_damped_oscillator_step_top verification failed");
        $finish;
    end

    initial begin
        logic [31:0] step_word;
        logic [31:0] count_word;
        int          run_len;
        bit          hold_done;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        sent         = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // advance from the zero state, then the default start point
        send_run(1'b0, 1);
        drain();
        send_run(1'b1, 2);
        drain();

        // full step with extreme start values: saturation, last flag, repeats
        write_regs(32'h0100_0000, 32'h7FFF_FF00, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3);
        send_run(1'b1, 4);
        drain();

        // zero step size with upper data bits set
        write_regs(32'hFE00_0000, 32'h8000_0000, 32'h0100_0000, 32'h0, 32'hFFFF_0002);
        send_run(1'b1, 3);
        drain();

        // zero step count, widest step size
        write_regs(32'h01FF_FFFF, 32'h0, 32'hFF00_0000, 32'h0080_0000, 32'h0);
        send_run(1'b1, 2);
        drain();

        // largest count, then step size and count changed after the restart
        write_regs(32'h0080_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF);
        send_run(1'b1, 2);
        drain();
        write_regs(32'h0000_0001, 32'h1234_5678, 32'h0, 32'h0, 32'h0000_FFFF);
        send_run(1'b0, 0);
        drain();
        write_regs(32'h0000_0001, 32'h1234_5678, 32'h0, 32'h0, 32'h0000_0001);
        send_run(1'b0, 0);
        drain();

        while (sent < ITEMS) begin
            idle_on = (sent < ITEMS - CALM_TAIL);
            step_word = $urandom;
            case ($urandom_range(0, 9))
                0:       step_word[24:0] = 25'h100_0000;
                1:       step_word[24:0] = 25'd0;
                2:       step_word[24:0] = 25'd1;
                3:       ;
                default: step_word[24:0] = 25'($urandom_range(1, 32'h40_0000));
            endcase
            count_word = $urandom;
            case ($urandom_range(0, 11))
                0:       count_word[15:0] = 16'd0;
                1:       count_word[15:0] = 16'hFFFF;
                2:       ;
                default: count_word[15:0] = 16'($urandom_range(1, 24));
            endcase
            write_regs(step_word, rand_start(), rand_start(), rand_start(), count_word);

            if (!hold_done && sent >= 400) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
            end
            run_len = $urandom_range(10, 40);
            send_item($urandom_range(0, 5) != 0);
            repeat (run_len - 1) send_item($urandom_range(0, 11) == 0);
            s_tvalid <= 1'b0;
            drain();
        end

        repeat (END_WAIT) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("rk4_damped_oscillator_step_top verification clean");
        else
            $display("rk4_damped_oscillator_step_top verification failed");
        $finish;
    end

endmodule
